FILE: hdl/u8vd_pkg.sv
// u8vd_pkg: shared types, status codes and the second-byte check used by the
// UTF-8 validating decoder. No dependencies; compile first.

package u8vd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int TAKEN_W = 3;
    localparam int STAT_W  = 4;

    typedef enum logic [STAT_W-1:0] {
        ST_OK              = 4'd0,
        ST_TRUNC           = 4'd1,
        ST_OVERLONG_LEAD   = 4'd2,
        ST_BEYOND_LEAD     = 4'd3,
        ST_STRAY_LEAD      = 4'd4,
        ST_OVERLONG_SECOND = 4'd5,
        ST_SURROGATE       = 4'd6,
        ST_BEYOND_SECOND   = 4'd7,
        ST_BAD_CONT        = 4'd8
    } status_t;

    localparam logic [BYTE_W-1:0] LEAD_E0 = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_ED = 8'hED;
    localparam logic [BYTE_W-1:0] LEAD_F0 = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_F4 = 8'hF4;

    // Decoder state carried between beats; expected_length of zero means idle.
    typedef struct packed {
        logic [2:0]        expected_length;
        logic [1:0]        bytes_received;
        logic [BYTE_W-1:0] lead_value;
        logic [CP_W-1:0]   partial_code;
        status_t           held_error;
    } dec_state_t;

    localparam dec_state_t STATE_IDLE = '{
        expected_length: 3'd0,
        bytes_received:  2'd0,
        lead_value:      '0,
        partial_code:    '0,
        held_error:      ST_OK
    };

    // One step's result.
    typedef struct packed {
        logic                emit;
        logic [CP_W-1:0]     code_point;
        logic [TAKEN_W-1:0]  bytes_taken;
        status_t             status;
    } step_result_t;

    // Classify the second byte of a sequence against its lead byte.
    function automatic status_t check_second(input logic [BYTE_W-1:0] lead,
                                             input logic [BYTE_W-1:0] c);
        status_t st;
        st = ST_BAD_CONT;
        unique case (lead)
            LEAD_E0:
            begin
                case (c) inside
                    [8'hA0:8'hBF]: st = ST_OK;
                    [8'h80:8'h9F]: st = ST_OVERLONG_SECOND;
                    default:       st = ST_BAD_CONT;
                endcase
            end
            LEAD_ED:
            begin
                case (c) inside
                    [8'h80:8'h9F]: st = ST_OK;
                    [8'hA0:8'hBF]: st = ST_SURROGATE;
                    default:       st = ST_BAD_CONT;
                endcase
            end
            LEAD_F0:
            begin
                case (c) inside
                    [8'h90:8'hBF]: st = ST_OK;
                    [8'h80:8'h8F]: st = ST_OVERLONG_SECOND;
                    default:       st = ST_BAD_CONT;
                endcase
            end
            LEAD_F4:
            begin
                case (c) inside
                    [8'h80:8'h8F]: st = ST_OK;
                    [8'h90:8'hBF]: st = ST_BEYOND_SECOND;
                    default:       st = ST_BAD_CONT;
                endcase
            end
            default:
            begin
                case (c) inside
                    [8'h80:8'hBF]: st = ST_OK;
                    default:       st = ST_BAD_CONT;
                endcase
            end
        endcase
        return st;
    endfunction

endpackage

FILE: hdl/u8vd_byte_if.sv
// u8vd_byte_if: valid/ready channel carrying one input byte per beat.
// Depends on u8vd_pkg for widths.

interface u8vd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [u8vd_pkg::BYTE_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hdl/u8vd_result_if.sv
// u8vd_result_if: valid/ready channel carrying one decode result per beat.
// Depends on u8vd_pkg for widths.

interface u8vd_result_if;
    logic                         valid;
    logic                         ready;
    logic [u8vd_pkg::CP_W-1:0]    code_point;
    logic [u8vd_pkg::TAKEN_W-1:0] bytes_taken;
    logic [u8vd_pkg::STAT_W-1:0]  status;

    modport source (output valid, output code_point, output bytes_taken, output status,
                    input ready);
    modport sink   (input valid, input code_point, input bytes_taken, input status,
                    output ready);
endinterface

FILE: hdl/u8vd_step.sv
// u8vd_step: combinational decode of one byte against the current sequence state.
// Depends on u8vd_pkg.

module u8vd_step
(
    input  u8vd_pkg::dec_state_t         state,
    input  logic [u8vd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         last_byte,
    output u8vd_pkg::dec_state_t         state_next,
    output u8vd_pkg::step_result_t       result
);

    logic [2:0]                   lead_len;
    u8vd_pkg::status_t            lead_err;
    logic [2:0]                   n;
    u8vd_pkg::status_t            cont_err;
    u8vd_pkg::status_t            held_next;
    logic [u8vd_pkg::CP_W-1:0]    lead_bits;
    logic [u8vd_pkg::CP_W-1:0]    code_next;

    // Lead byte classification
    always_comb
    begin
        lead_len  = 3'd0;
        lead_err  = u8vd_pkg::ST_OK;
        lead_bits = '0;
        unique case (data_byte) inside
            [8'h00:8'h7F]: lead_len = 3'd1;
            [8'h80:8'hBF]: lead_err = u8vd_pkg::ST_STRAY_LEAD;
            [8'hC0:8'hC1]: lead_err = u8vd_pkg::ST_OVERLONG_LEAD;
            [8'hC2:8'hDF]:
            begin
                lead_len  = 3'd2;
                lead_bits = {16'd0, data_byte[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                lead_len  = 3'd3;
                lead_bits = {17'd0, data_byte[3:0]};
            end
            [8'hF0:8'hF4]:
            begin
                lead_len  = 3'd4;
                lead_bits = {18'd0, data_byte[2:0]};
            end
            default:       lead_err = u8vd_pkg::ST_BEYOND_LEAD;
        endcase
    end

    // Continuation byte checks; keep only the first error of the sequence
    always_comb
    begin
        n = {1'b0, state.bytes_received} + 3'd1;
        if (n == 3'd2)
            cont_err = u8vd_pkg::check_second(state.lead_value, data_byte);
        else if (data_byte[7:6] == 2'b10)
            cont_err = u8vd_pkg::ST_OK;
        else
            cont_err = u8vd_pkg::ST_BAD_CONT;
        held_next = (state.held_error == u8vd_pkg::ST_OK) ? cont_err : state.held_error;
        code_next = {state.partial_code[u8vd_pkg::CP_W-7:0], data_byte[5:0]};
    end

    always_comb
    begin
        state_next         = state;
        result.emit        = 1'b0;
        result.code_point  = '0;
        result.bytes_taken = 3'd1;
        result.status      = u8vd_pkg::ST_OK;
        if (state.expected_length == 3'd0)
        begin
            if (lead_len == 3'd1)
            begin
                result.emit       = 1'b1;
                result.code_point = {13'd0, data_byte};
            end
            else if (lead_len == 3'd0)
            begin
                result.emit   = 1'b1;
                result.status = lead_err;
            end
            else if (last_byte)
            begin
                result.emit   = 1'b1;
                result.status = u8vd_pkg::ST_TRUNC;
            end
            else
            begin
                state_next.expected_length = lead_len;
                state_next.bytes_received  = 2'd1;
                state_next.lead_value      = data_byte;
                state_next.partial_code    = lead_bits;
                state_next.held_error      = u8vd_pkg::ST_OK;
            end
        end
        else
        begin
            result.bytes_taken = n;
            if (n >= state.expected_length)
            begin
                result.emit   = 1'b1;
                result.status = held_next;
                if (held_next == u8vd_pkg::ST_OK)
                    result.code_point = code_next;
            end
            else if (last_byte)
            begin
                result.emit   = 1'b1;
                result.status = u8vd_pkg::ST_TRUNC;
            end
            else
            begin
                state_next.bytes_received = n[1:0];
                state_next.partial_code   = code_next;
                state_next.held_error     = held_next;
            end
        end
        // Every result returns the decoder to idle
        if (result.emit)
            state_next = u8vd_pkg::STATE_IDLE;
    end

endmodule

FILE: hdl/utf8_validating_decoder.sv
// utf8_validating_decoder: top level; input register, decode step, result register.
// Depends on u8vd_pkg, u8vd_byte_if, u8vd_result_if and u8vd_step.
//
// Usage:
//   byte_stream carries one UTF-8 byte per beat, with last_byte set on the
//   final byte of a string. result_stream carries one beat per finished
//   sequence or per error: the code point (zero unless status is ok), the
//   number of bytes that the beat covers, and the status code. Bytes that
//   open or continue a sequence produce no result beat.
//   Path: an accepted byte is held in the input register, and its result is
//   registered in the result register before it appears on result_stream.
//   Throughput: one byte per cycle while no stall holds the input; the decode
//   step is a single pass of range compares and a 6-bit shift-accumulate
//   between the input register and the result register.
//   Stall: the result register holds its beat while result_stream.ready is
//   low; the input register then holds its byte and byte_stream.ready drops
//   once that register is occupied. No beat is lost or repeated.
//   Reset: rst_n low clears both valid flags and returns the decoder to
//   idle with no sequence open and no error held.

module utf8_validating_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    u8vd_byte_if.sink            byte_stream,
    u8vd_result_if.source        result_stream
);

    // Input register
    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [u8vd_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                         in_last_reg;

    // Sequence state
    u8vd_pkg::dec_state_t         state_reg;
    u8vd_pkg::dec_state_t         state_next;

    // Result register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    u8vd_pkg::step_result_t       out_reg;

    u8vd_pkg::step_result_t       step_res;
    logic                         advance;
    logic                         in_take;

    // Advance the held byte whenever the result register can take a beat.
    assign advance = in_valid_reg && (!out_valid_reg || result_stream.ready);
    assign byte_stream.ready = !in_valid_reg || advance;
    assign in_take = byte_stream.valid && byte_stream.ready;

    u8vd_step u_step
    (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = step_res.emit;
        else if (result_stream.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= u8vd_pkg::STATE_IDLE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers: load on a beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_stream.data_byte;
            in_last_reg <= byte_stream.last_byte;
        end
        if (advance && step_res.emit)
            out_reg <= step_res;
    end

    assign result_stream.valid       = out_valid_reg;
    assign result_stream.code_point  = out_reg.code_point;
    assign result_stream.bytes_taken = out_reg.bytes_taken;
    assign result_stream.status      = out_reg.status;

endmodule
